### src/lcd_seq_pkg.sv
// -----------------------------------------------------------------------------
// lcd_seq_pkg
// Shared types and constants of the character LCD bus sequencer.
// -----------------------------------------------------------------------------
package lcd_seq_pkg;

   // request codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_SEND  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;
   localparam logic [1:0] CMD_MOVE  = 2'd3;

   // timing in 250 ns units
   localparam logic [15:0] CPQ_RESET          = 16'd42;
   localparam logic [27:0] POLL_QUARTERS      = 28'd2;
   localparam logic [27:0] WAIT_QUARTERS      = 28'd32;
   localparam logic [27:0] STROBE_QUARTERS    = 28'd1;
   localparam logic [27:0] MS_QUARTERS        = 28'd4000;
   localparam logic [27:0] POST_CHAR_QUARTERS = 28'd172;
   localparam logic [27:0] POST_MOVE_QUARTERS = 28'd156;

   // display address bits
   localparam logic [7:0] SET_ADDR_BASE = 8'h80;
   localparam logic [7:0] LINE2_OFFSET  = 8'h40;
   localparam int         BUSY_BIT      = 7;

   // decoded request held in the input register
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  send_byte;
      logic        data_select;
      logic [27:0] post_quarters;
      logic        move_bad;
      logic [7:0]  bus;
   } req_dec_type;

   // one result item
   typedef struct packed {
      logic       lcd_enable;
      logic       lcd_reg_select;
      logic       lcd_read_write;
      logic [7:0] lcd_data_out;
      logic       data_drive;
      logic       ready_res;
      logic       rejected;
   } result_type;

endpackage

### src/lcd_seq_in_stage.sv
// -----------------------------------------------------------------------------
// lcd_seq_in_stage
// Input register: decodes a request into byte, register select and post delay.
// -----------------------------------------------------------------------------
module lcd_seq_in_stage #(
   parameter int LINE_WIDTH = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_cmd,
   input  logic [7:0]               req_byte_value,
   input  logic [15:0]              req_delay_amount,
   input  logic                     req_delay_in_us,
   input  logic [7:0]               req_position,
   input  logic [1:0]               req_line_number,
   input  logic [7:0]               req_bus_in,
   input  logic                     take,
   output logic                     dec_valid,
   output lcd_seq_pkg::req_dec_type dec
);

   logic                     dec_valid_ff, dec_valid_in;
   lcd_seq_pkg::req_dec_type dec_ff, dec_in;
   logic                     accept;
   logic [7:0]               move_addr;
   logic [27:0]              cmd_post;

   // hold while the stage is full and cannot hand its item on
   assign req_stall = dec_valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   // decode request fields
   always_comb begin
      move_addr = req_position - 8'd1;
      if (req_line_number == 2'd2) begin
         move_addr = move_addr + lcd_seq_pkg::LINE2_OFFSET;
      end
      if (req_delay_in_us) begin
         cmd_post = {10'd0, req_delay_amount, 2'b00};
      end else begin
         cmd_post = 28'(req_delay_amount) * lcd_seq_pkg::MS_QUARTERS;
      end

      dec_in.cmd         = req_cmd;
      dec_in.bus         = req_bus_in;
      dec_in.move_bad    = (req_position == 8'd0) || (req_position > 8'(LINE_WIDTH)) ||
                           (req_line_number != 2'd1 && req_line_number != 2'd2);
      dec_in.send_byte   = req_byte_value;
      dec_in.data_select = 1'b0;
      dec_in.post_quarters = cmd_post;
      case (req_cmd)
         lcd_seq_pkg::CMD_WRITE: begin
            dec_in.data_select   = 1'b1;
            dec_in.post_quarters = lcd_seq_pkg::POST_CHAR_QUARTERS;
         end
         lcd_seq_pkg::CMD_MOVE: begin
            dec_in.send_byte     = lcd_seq_pkg::SET_ADDR_BASE | move_addr;
            dec_in.post_quarters = lcd_seq_pkg::POST_MOVE_QUARTERS;
         end
         default: begin
         end
      endcase
   end

   // advance the stage
   always_comb begin
      if (accept) begin
         dec_valid_in = 1'b1;
      end else if (take) begin
         dec_valid_in = 1'b0;
      end else begin
         dec_valid_in = dec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= dec_valid_in;
      end
      if (accept) begin
         dec_ff <= dec_in;
      end
   end

   assign dec_valid = dec_valid_ff;
   assign dec       = dec_ff;

endmodule

### src/lcd_seq_core.sv
// -----------------------------------------------------------------------------
// lcd_seq_core
// Bus sequencer state, timing counters, pin levels and the result register.
// -----------------------------------------------------------------------------
module lcd_seq_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [15:0]              csr_wr_data,
   input  logic                     dec_valid,
   input  lcd_seq_pkg::req_dec_type dec,
   output logic                     take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lcd_seq_pkg::result_type  result
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_POLL, PH_WAIT, PH_STROBE, PH_POST
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [15:0]             cpq_ff, cpq_in;
   logic [15:0]             clock_count_ff, clock_count_in;
   logic [27:0]             quarter_count_ff, quarter_count_in;
   logic [27:0]             post_quarters_ff, post_quarters_in;
   logic [7:0]              pending_byte_ff, pending_byte_in;
   logic                    pending_sel_ff, pending_sel_in;
   logic                    pin_e_ff, pin_e_in;
   logic                    pin_rs_ff, pin_rs_in;
   logic                    pin_rw_ff, pin_rw_in;
   logic                    pin_drive_ff, pin_drive_in;
   logic [7:0]              pin_data_ff, pin_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lcd_seq_pkg::result_type result_ff, result_in;
   logic [15:0]             cpq_eff;
   logic [15:0]             clock_next;
   logic [27:0]             quarter_next;
   logic                    rej;

   // the result register takes a transfer when empty or being drained
   assign take = dec_valid && (!rsp_valid_ff || !rsp_stall);

   assign cpq_in = csr_wr_en ? csr_wr_data : cpq_ff;

   // next state for the item in the input register
   always_comb begin
      phase_in         = phase_ff;
      clock_count_in   = clock_count_ff;
      quarter_count_in = quarter_count_ff;
      post_quarters_in = post_quarters_ff;
      pending_byte_in  = pending_byte_ff;
      pending_sel_in   = pending_sel_ff;
      pin_e_in         = pin_e_ff;
      pin_rs_in        = pin_rs_ff;
      pin_rw_in        = pin_rw_ff;
      pin_drive_in     = pin_drive_ff;
      pin_data_in      = pin_data_ff;
      rej              = 1'b0;
      cpq_eff          = (cpq_ff == 16'd0) ? 16'd1 : cpq_ff;
      clock_next       = clock_count_ff + 16'd1;
      quarter_next     = quarter_count_ff + 28'd1;

      if (dec.cmd == lcd_seq_pkg::CMD_TICK) begin
         if (phase_ff != PH_IDLE) begin
            clock_count_in = clock_next;
            if (clock_next >= cpq_eff) begin
               // end of one quarter
               clock_count_in   = 16'd0;
               quarter_count_in = quarter_next;
               case (phase_ff)
                  PH_POLL: begin
                     if (quarter_next >= lcd_seq_pkg::POLL_QUARTERS) begin
                        quarter_count_in = 28'd0;
                        if (!dec.bus[lcd_seq_pkg::BUSY_BIT]) begin
                           phase_in = PH_WAIT;
                           pin_e_in = 1'b0;
                        end
                     end
                  end
                  PH_WAIT: begin
                     if (quarter_next >= lcd_seq_pkg::WAIT_QUARTERS) begin
                        quarter_count_in = 28'd0;
                        phase_in         = PH_STROBE;
                        pin_e_in         = 1'b1;
                        pin_rs_in        = pending_sel_ff;
                        pin_rw_in        = 1'b0;
                        pin_drive_in     = 1'b1;
                        pin_data_in      = pending_byte_ff;
                     end
                  end
                  PH_STROBE: begin
                     if (quarter_next >= lcd_seq_pkg::STROBE_QUARTERS) begin
                        quarter_count_in = 28'd0;
                        pin_e_in         = 1'b0;
                        phase_in = (post_quarters_ff == 28'd0) ? PH_IDLE : PH_POST;
                     end
                  end
                  PH_POST: begin
                     if (quarter_next >= post_quarters_ff) begin
                        quarter_count_in = 28'd0;
                        phase_in         = PH_IDLE;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         rej = 1'b1;
      end else if (dec.cmd == lcd_seq_pkg::CMD_MOVE && dec.move_bad) begin
         rej = 1'b1;
      end else begin
         // start a request with a status poll
         pending_byte_in  = dec.send_byte;
         pending_sel_in   = dec.data_select;
         post_quarters_in = dec.post_quarters;
         clock_count_in   = 16'd0;
         quarter_count_in = 28'd0;
         phase_in         = PH_POLL;
         pin_e_in         = 1'b1;
         pin_rs_in        = 1'b0;
         pin_rw_in        = 1'b1;
         pin_drive_in     = 1'b0;
         pin_data_in      = 8'd0;
      end

      result_in.lcd_enable     = pin_e_in;
      result_in.lcd_reg_select = pin_rs_in;
      result_in.lcd_read_write = pin_rw_in;
      result_in.lcd_data_out   = pin_data_in;
      result_in.data_drive     = pin_drive_in;
      result_in.ready_res      = (phase_in == PH_IDLE);
      result_in.rejected       = rej;
   end

   // drop the result once it is taken
   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         cpq_ff           <= lcd_seq_pkg::CPQ_RESET;
         clock_count_ff   <= 16'd0;
         quarter_count_ff <= 28'd0;
         post_quarters_ff <= 28'd0;
         pending_byte_ff  <= 8'd0;
         pending_sel_ff   <= 1'b0;
         pin_e_ff         <= 1'b0;
         pin_rs_ff        <= 1'b0;
         pin_rw_ff        <= 1'b0;
         pin_drive_ff     <= 1'b0;
         pin_data_ff      <= 8'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cpq_ff       <= cpq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff         <= phase_in;
            clock_count_ff   <= clock_count_in;
            quarter_count_ff <= quarter_count_in;
            post_quarters_ff <= post_quarters_in;
            pending_byte_ff  <= pending_byte_in;
            pending_sel_ff   <= pending_sel_in;
            pin_e_ff         <= pin_e_in;
            pin_rs_ff        <= pin_rs_in;
            pin_rw_ff        <= pin_rw_in;
            pin_drive_ff     <= pin_drive_in;
            pin_data_ff      <= pin_data_in;
         end
      end
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

### src/char_lcd_bus_sequencer_top.sv
// Datapath: a request transfer passes the input register, then the result register.
// Throughput: 1 item per cycle unless rsp_stall holds; sequencer state updates once
// per item in a single pass between the input register and the result register.
// Reset: synchronous, active high; sequencer idle, pins low, bus released,
// quarter length back to CPQ_RESET. No clearing pass.
// -----------------------------------------------------------------------------
// char_lcd_bus_sequencer_top
// 8-bit character LCD bus sequencer: status poll, setup wait, strobe, post delay.
// -----------------------------------------------------------------------------
module char_lcd_bus_sequencer_top #(
   parameter int LINE_WIDTH = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_byte_value,
   input  logic [15:0] req_delay_amount,
   input  logic        req_delay_in_us,
   input  logic [7:0]  req_position,
   input  logic [1:0]  req_line_number,
   input  logic [7:0]  req_bus_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_lcd_enable,
   output logic        rsp_lcd_reg_select,
   output logic        rsp_lcd_read_write,
   output logic [7:0]  rsp_lcd_data_out,
   output logic        rsp_data_drive,
   output logic        rsp_ready_res,
   output logic        rsp_rejected
);

   logic                     take;
   logic                     dec_valid;
   lcd_seq_pkg::req_dec_type dec;
   lcd_seq_pkg::result_type  result;

   // decode and register requests
   lcd_seq_in_stage #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_in_stage (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_byte_value   (req_byte_value),
      .req_delay_amount (req_delay_amount),
      .req_delay_in_us  (req_delay_in_us),
      .req_position     (req_position),
      .req_line_number  (req_line_number),
      .req_bus_in       (req_bus_in),
      .take             (take),
      .dec_valid        (dec_valid),
      .dec              (dec)
   );

   // sequencer and result register
   lcd_seq_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .dec_valid   (dec_valid),
      .dec         (dec),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .result      (result)
   );

   assign rsp_lcd_enable     = result.lcd_enable;
   assign rsp_lcd_reg_select = result.lcd_reg_select;
   assign rsp_lcd_read_write = result.lcd_read_write;
   assign rsp_lcd_data_out   = result.lcd_data_out;
   assign rsp_data_drive     = result.data_drive;
   assign rsp_ready_res      = result.ready_res;
   assign rsp_rejected       = result.rejected;

`ifndef ASSERT_OFF
   // bus is never driven during a status read
   a_no_drive_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lcd_read_write |-> !rsp_data_drive)
      else $error("data bus driven while RW reads");

   // an idle sequencer has E low
   a_idle_e_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready_res |-> !rsp_lcd_enable)
      else $error("E high while idle");

   // a write strobe always drives the bus
   a_strobe_drives: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lcd_enable && !rsp_lcd_read_write |-> rsp_data_drive)
      else $error("write strobe without bus drive");

   // input side stalls only when the result side holds
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with free result register");
`endif

endmodule

### tb/char_lcd_bus_sequencer_top_test.sv
// -----------------------------------------------------------------------------
// char_lcd_bus_sequencer_top_test
// Self-checking bench for the LCD bus sequencer. A directed table covers reset
// levels, range rejects, busy rejects, repeated busy polls, quarter-length
// changes in flight and the post delays of each request kind. Random request
// sequences with tick runs follow. Every result transfer is checked field by
// field against an in-bench timing model of the bus or a directed row's fixed levels.
// -----------------------------------------------------------------------------
module char_lcd_bus_sequencer_top_test;

   localparam int LCD_COLUMNS   = 20;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int SECTION_ITEMS = 250;
   localparam int QUIET_ITEMS   = 200;
   localparam int DRAIN_CYCLES  = 5000;
   localparam int PRINT_LIMIT   = 100;

   // bus timing in 250 ns quarters
   localparam logic [27:0] Q_POLL      = 28'd2;
   localparam logic [27:0] Q_SETUP     = 28'd32;
   localparam logic [27:0] Q_STROBE    = 28'd1;
   localparam logic [31:0] Q_PER_US    = 32'd4;
   localparam logic [31:0] Q_PER_MS    = 32'd4000;
   localparam logic [31:0] Q_CHAR_POST = 32'd172;
   localparam logic [31:0] Q_MOVE_POST = 32'd156;
   localparam logic [7:0]  ADDR_CMD    = 8'h80;
   localparam logic [7:0]  ADDR_LINE2  = 8'h40;
   localparam int          STATUS_BUSY = 7;

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_POLL, SEQ_SETUP, SEQ_STROBE, SEQ_POST
   } seq_phase_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  byte_value;
      logic [15:0] delay_amount;
      logic        delay_in_us;
      logic [7:0]  position;
      logic [1:0]  line_number;
      logic [7:0]  bus_in;
   } lcd_item_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // one directed step; a CSR row carries the register value in amount
   typedef struct packed {
      row_kind_type            kind;
      logic [1:0]              cmd;
      logic [7:0]              byte_value;
      logic [15:0]             amount;
      logic                    in_us;
      logic [7:0]              position;
      logic [1:0]              line;
      logic [7:0]              bus;
      logic [15:0]             reps;
      logic                    typed;
      lcd_seq_pkg::result_type want;
   } plan_row_type;

   // levels that can be read straight off the bus rules
   localparam lcd_seq_pkg::result_type RES_NONE        = '0;
   localparam lcd_seq_pkg::result_type RES_IDLE        =
      '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0};
   localparam lcd_seq_pkg::result_type RES_IDLE_REJECT =
      '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1};
   localparam lcd_seq_pkg::result_type RES_POLL        =
      '{1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0};
   localparam lcd_seq_pkg::result_type RES_POLL_REJECT =
      '{1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1};

   localparam int PLAN_ROWS = 23;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // idle after reset, then moves out of range
      '{ROW_ITEM, lcd_seq_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, 8'd0,   2'd0, 8'h00,
        16'd1,   1'b1, RES_IDLE},
      '{ROW_ITEM, lcd_seq_pkg::CMD_MOVE,  8'h00, 16'h0000, 1'b0, 8'd0,   2'd1, 8'h00,
        16'd1,   1'b1, RES_IDLE_REJECT},
      '{ROW_ITEM, lcd_seq_pkg::CMD_MOVE,  8'h00, 16'h0000, 1'b1, 8'd21,  2'd2, 8'h00,
        16'd1,   1'b1, RES_IDLE_REJECT},
      '{ROW_ITEM, lcd_seq_pkg::CMD_MOVE,  8'h00, 16'h0000, 1'b0, 8'd1,   2'd0, 8'h00,
        16'd1,   1'b1, RES_IDLE_REJECT},
      '{ROW_ITEM, lcd_seq_pkg::CMD_MOVE,  8'hFF, 16'hFFFF, 1'b1, 8'd255, 2'd3, 8'hFF,
        16'd1,   1'b1, RES_IDLE_REJECT},
      // longest quarter, start a send, reject requests while busy
      '{ROW_CSR,  lcd_seq_pkg::CMD_TICK,  8'h00, 16'hFFFF, 1'b0, 8'd0,   2'd0, 8'h00,
        16'd1,   1'b0, RES_NONE},
      '{ROW_ITEM, lcd_seq_pkg::CMD_SEND,  8'hFF, 16'h0000, 1'b1, 8'd0,   2'd0, 8'h00,
        16'd1,   1'b1, RES_POLL},
      '{ROW_ITEM, lcd_seq_pkg::CMD_WRITE, 8'h00, 16'hFFFF, 1'b0, 8'd0,   2'd0, 8'h00,
        16'd1,   1'b1, RES_POLL_REJECT},
      '{ROW_ITEM, lcd_seq_pkg::CMD_MOVE,  8'h00, 16'h0000, 1'b0, 8'd1,   2'd1, 8'h00,
        16'd1,   1'b1, RES_POLL_REJECT},
      '{ROW_ITEM, lcd_seq_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, 8'd0,   2'd0, 8'h00,
        16'd6,   1'b0, RES_NONE},
      // shrink the quarter below the running count, then busy polls
      '{ROW_CSR,  lcd_seq_pkg::CMD_TICK,  8'h00, 16'h0001, 1'b0, 8'd0,   2'd0, 8'h00,
        16'd1,   1'b0, RES_NONE},
      '{ROW_ITEM, lcd_seq_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, 8'd0,   2'd0, 8'h80,
        16'd4,   1'b0, RES_NONE},
      '{ROW_ITEM, lcd_seq_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, 8'd0,   2'd0, 8'h7F,
        16'd2,   1'b0, RES_NONE},
      // setup wait, strobe and zero post delay, then bus held while idle
      '{ROW_ITEM, lcd_seq_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, 8'd0,   2'd0, 8'hFF,
        16'd33,  1'b0, RES_NONE},
      '{ROW_ITEM, lcd_seq_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, 8'd0,   2'd0, 8'h00,
        16'd1,   1'b0, RES_NONE},
      // zero quarter length is treated as a length of 1
      '{ROW_CSR,  lcd_seq_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, 8'd0,   2'd0, 8'h00,
        16'd1,   1'b0, RES_NONE},
      '{ROW_ITEM, lcd_seq_pkg::CMD_WRITE, 8'h00, 16'h0000, 1'b0, 8'd0,   2'd0, 8'h00,
        16'd1,   1'b0, RES_NONE},
      '{ROW_ITEM, lcd_seq_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, 8'd0,   2'd0, 8'h00,
        16'd210, 1'b0, RES_NONE},
      '{ROW_ITEM, lcd_seq_pkg::CMD_MOVE,  8'h00, 16'h0000, 1'b0, 8'd20,  2'd2, 8'h00,
        16'd1,   1'b0, RES_NONE},
      '{ROW_ITEM, lcd_seq_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, 8'd0,   2'd0, 8'h00,
        16'd195, 1'b0, RES_NONE},
      '{ROW_ITEM, lcd_seq_pkg::CMD_MOVE,  8'h00, 16'h0000, 1'b0, 8'd1,   2'd1, 8'h00,
        16'd1,   1'b0, RES_NONE},
      '{ROW_ITEM, lcd_seq_pkg::CMD_TICK,  8'h00, 16'h0000, 1'b0, 8'd0,   2'd0, 8'h00,
        16'd195, 1'b0, RES_NONE},
      // back to the reset quarter length
      '{ROW_CSR,  lcd_seq_pkg::CMD_TICK,  8'h00, 16'd42,   1'b0, 8'd0,   2'd0, 8'h00,
        16'd1,   1'b0, RES_NONE}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = lcd_seq_pkg::CMD_TICK;
   logic [7:0]  req_byte_value = 8'd0;
   logic [15:0] req_delay_amount = 16'd0;
   logic        req_delay_in_us = 1'b0;
   logic [7:0]  req_position = 8'd0;
   logic [1:0]  req_line_number = 2'd0;
   logic [7:0]  req_bus_in = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_lcd_enable;
   logic        rsp_lcd_reg_select;
   logic        rsp_lcd_read_write;
   logic [7:0]  rsp_lcd_data_out;
   logic        rsp_data_drive;
   logic        rsp_ready_res;
   logic        rsp_rejected;

   // timing model state
   seq_phase_type seq_phase;
   logic [15:0]   quarter_len;
   logic [15:0]   tick_count;
   logic [27:0]   quarter_ctr;
   logic [27:0]   post_len;
   logic [7:0]    held_byte;
   logic          held_rs;
   logic          pin_e, pin_rs, pin_rw, pin_drive;
   logic [7:0]    pin_data;

   lcd_seq_pkg::result_type levels_due [$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          items_sent = 0;
   int          stall_left = 0;
   bit          idling_on = 1'b1;

   char_lcd_bus_sequencer_top #(.LINE_WIDTH(LCD_COLUMNS)) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_byte_value     (req_byte_value),
      .req_delay_amount   (req_delay_amount),
      .req_delay_in_us    (req_delay_in_us),
      .req_position       (req_position),
      .req_line_number    (req_line_number),
      .req_bus_in         (req_bus_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_lcd_enable     (rsp_lcd_enable),
      .rsp_lcd_reg_select (rsp_lcd_reg_select),
      .rsp_lcd_read_write (rsp_lcd_read_write),
      .rsp_lcd_data_out   (rsp_lcd_data_out),
      .rsp_data_drive     (rsp_data_drive),
      .rsp_ready_res      (rsp_ready_res),
      .rsp_rejected       (rsp_rejected)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string msg);
      // keep the log short on a badly broken build
      if (mismatches < PRINT_LIMIT)
         $display("mismatch at result %0d: %s", results_seen, msg);
      mismatches++;
   endtask

   task automatic check_field(input string field, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
   endtask

   task automatic drive_pins(input logic e, input logic rs, input logic rw, input logic drv,
                             input logic [7:0] data);
      pin_e     = e;
      pin_rs    = rs;
      pin_rw    = rw;
      pin_drive = drv;
      pin_data  = data;
   endtask

   // latch a request and start the status poll with the bus released
   task automatic open_request(input logic [7:0] byte_v, input logic rs, input logic [31:0] post);
      held_byte   = byte_v;
      held_rs     = rs;
      post_len    = post[27:0];
      tick_count  = 16'd0;
      quarter_ctr = 28'd0;
      seq_phase   = SEQ_POLL;
      drive_pins(1'b1, 1'b0, 1'b1, 1'b0, 8'h00);
   endtask

   // advance the sequence at the end of one quarter
   task automatic close_quarter(input logic [7:0] bus);
      quarter_ctr = quarter_ctr + 28'd1;
      case (seq_phase)
         SEQ_POLL: begin
            if (quarter_ctr >= Q_POLL) begin
               quarter_ctr = 28'd0;
               if (!bus[STATUS_BUSY]) begin
                  seq_phase = SEQ_SETUP;
                  drive_pins(1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
               end
            end
         end
         SEQ_SETUP: begin
            if (quarter_ctr >= Q_SETUP) begin
               quarter_ctr = 28'd0;
               seq_phase   = SEQ_STROBE;
               drive_pins(1'b1, held_rs, 1'b0, 1'b1, held_byte);
            end
         end
         SEQ_STROBE: begin
            if (quarter_ctr >= Q_STROBE) begin
               quarter_ctr = 28'd0;
               drive_pins(1'b0, held_rs, 1'b0, 1'b1, held_byte);
               seq_phase = (post_len == 28'd0) ? SEQ_IDLE : SEQ_POST;
            end
         end
         SEQ_POST: begin
            if (quarter_ctr >= post_len) begin
               quarter_ctr = 28'd0;
               seq_phase   = SEQ_IDLE;
            end
         end
         default: seq_phase = SEQ_IDLE;
      endcase
   endtask

   // pin levels and flags after one item
   task automatic predict_bus_levels(input lcd_item_type it,
                                     output lcd_seq_pkg::result_type lv);
      logic        rej;
      logic [15:0] span;
      logic [7:0]  addr;
      rej = 1'b0;
      if (it.cmd == lcd_seq_pkg::CMD_TICK) begin
         if (seq_phase != SEQ_IDLE) begin
            span       = (quarter_len == 16'd0) ? 16'd1 : quarter_len;
            tick_count = tick_count + 16'd1;
            if (tick_count >= span) begin
               tick_count = 16'd0;
               close_quarter(it.bus_in);
            end
         end
      end else if (seq_phase != SEQ_IDLE) begin
         rej = 1'b1;
      end else if (it.cmd == lcd_seq_pkg::CMD_SEND) begin
         open_request(it.byte_value, 1'b0,
                      it.delay_in_us ? {16'd0, it.delay_amount} * Q_PER_US
                                     : {16'd0, it.delay_amount} * Q_PER_MS);
      end else if (it.cmd == lcd_seq_pkg::CMD_WRITE) begin
         open_request(it.byte_value, 1'b1, Q_CHAR_POST);
      end else if (it.position == 8'd0 || int'(it.position) > LCD_COLUMNS ||
                   it.line_number == 2'd0 || it.line_number == 2'd3) begin
         rej = 1'b1;
      end else begin
         addr = it.position - 8'd1;
         if (it.line_number == 2'd2)
            addr = addr + ADDR_LINE2;
         open_request(ADDR_CMD | addr, 1'b0, Q_MOVE_POST);
      end
      lv.lcd_enable     = pin_e;
      lv.lcd_reg_select = pin_rs;
      lv.lcd_read_write = pin_rw;
      lv.lcd_data_out   = pin_data;
      lv.data_drive     = pin_drive;
      lv.ready_res      = (seq_phase == SEQ_IDLE);
      lv.rejected       = rej;
   endtask

   function automatic lcd_item_type rand_item();
      lcd_item_type it;
      it.cmd          = 2'($urandom);
      it.byte_value   = 8'($urandom);
      it.delay_amount = 16'($urandom);
      it.delay_in_us  = 1'($urandom);
      it.position     = 8'($urandom);
      it.line_number  = 2'($urandom);
      it.bus_in       = 8'($urandom);
      return it;
   endfunction

   // predict, then hold the item on the request port until it transfers
   task automatic push_request(input lcd_item_type it, input logic typed,
                               input lcd_seq_pkg::result_type want);
      lcd_seq_pkg::result_type lv;
      int                      gap;
      predict_bus_levels(it, lv);
      levels_due.push_back(typed ? want : lv);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_cmd          <= it.cmd;
      req_byte_value   <= it.byte_value;
      req_delay_amount <= it.delay_amount;
      req_delay_in_us  <= it.delay_in_us;
      req_position     <= it.position;
      req_line_number  <= it.line_number;
      req_bus_in       <= it.bus_in;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // write the quarter length once no transfer is in flight
   task automatic write_quarter_len(input logic [15:0] value);
      @(negedge clock) req_valid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock) csr_wr_en <= 1'b0;
      quarter_len = value;
   endtask

   // random stall bursts on the result side
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : rsp_watch
      lcd_seq_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (levels_due.size() == 0) begin
            report_mismatch("result with no expectation waiting");
         end else begin
            want = levels_due.pop_front();
            check_field("lcd_enable", 8'(rsp_lcd_enable), 8'(want.lcd_enable));
            check_field("lcd_reg_select", 8'(rsp_lcd_reg_select), 8'(want.lcd_reg_select));
            check_field("lcd_read_write", 8'(rsp_lcd_read_write), 8'(want.lcd_read_write));
            check_field("lcd_data_out", rsp_lcd_data_out, want.lcd_data_out);
            check_field("data_drive", 8'(rsp_data_drive), 8'(want.data_drive));
            check_field("ready_res", 8'(rsp_ready_res), 8'(want.ready_res));
            check_field("rejected", 8'(rsp_rejected), 8'(want.rejected));
         end
      end
   end

   initial begin
      lcd_item_type it;
      int           r;
      int           base;
      int           section;
      int           pick;
      int           w;
      logic [15:0]  qlen;

      seq_phase   = SEQ_IDLE;
      quarter_len = 16'd42;
      tick_count  = 16'd0;
      quarter_ctr = 28'd0;
      post_len    = 28'd0;
      held_byte   = 8'd0;
      held_rs     = 1'b0;
      drive_pins(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);

      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // walk the directed table
      for (r = 0; r < PLAN_ROWS; r++) begin
         if (PLAN[r].kind == ROW_CSR) begin
            write_quarter_len(PLAN[r].amount);
         end else begin
            it.cmd          = PLAN[r].cmd;
            it.byte_value   = PLAN[r].byte_value;
            it.delay_amount = PLAN[r].amount;
            it.delay_in_us  = PLAN[r].in_us;
            it.position     = PLAN[r].position;
            it.line_number  = PLAN[r].line;
            it.bus_in       = PLAN[r].bus;
            repeat (PLAN[r].reps) push_request(it, PLAN[r].typed, PLAN[r].want);
         end
      end

      // random requests, each followed by ticks, with some rejected requests mixed in, until the sequencer is idle
      base    = items_sent;
      section = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         if (items_sent - base >= section * SECTION_ITEMS) begin
            case (section)
               0:       qlen = 16'd1;
               1:       qlen = 16'd2;
               2:       qlen = 16'd0;
               default: qlen = 16'($urandom_range(1, 3));
            endcase
            write_quarter_len(qlen);
            section++;
         end
         if (items_sent - base >= RANDOM_ITEMS - QUIET_ITEMS)
            idling_on = 1'b0;

         pick = $urandom_range(0, 99);
         it   = rand_item();
         if (pick < 10) begin
            // noise while idle; no send, since a random one may carry a long millisecond delay
            if (it.cmd == lcd_seq_pkg::CMD_SEND)
               it.cmd = lcd_seq_pkg::CMD_MOVE;
         end else if (pick < 55) begin
            it.cmd          = lcd_seq_pkg::CMD_SEND;
            it.delay_in_us  = ($urandom_range(0, 4) != 0);
            it.delay_amount = it.delay_in_us ? 16'($urandom_range(0, 15)) : 16'd0;
         end else if (pick < 70) begin
            it.cmd = lcd_seq_pkg::CMD_WRITE;
         end else if (pick < 88) begin
            it.cmd         = lcd_seq_pkg::CMD_MOVE;
            it.position    = 8'($urandom_range(1, LCD_COLUMNS));
            it.line_number = 2'($urandom_range(1, 2));
         end else begin
            // moves at the edges of the line
            it.cmd = lcd_seq_pkg::CMD_MOVE;
            case ($urandom_range(0, 3))
               0:       it.position = 8'd0;
               1:       it.position = 8'd1;
               2:       it.position = 8'(LCD_COLUMNS);
               default: it.position = 8'(LCD_COLUMNS + 1);
            endcase
         end
         push_request(it, 1'b0, RES_NONE);

         while (seq_phase != SEQ_IDLE) begin
            it = rand_item();
            if ($urandom_range(0, 19) != 0) begin
               it.cmd = lcd_seq_pkg::CMD_TICK;
               if (seq_phase == SEQ_POLL)
                  it.bus_in[STATUS_BUSY] = ($urandom_range(0, 2) == 0);
            end else if (it.cmd == lcd_seq_pkg::CMD_TICK) begin
               it.cmd = lcd_seq_pkg::CMD_WRITE;
            end
            push_request(it, 1'b0, RES_NONE);
         end
      end

      // drain, then let the pipeline settle
      @(negedge clock) req_valid <= 1'b0;
      for (w = 0; w < DRAIN_CYCLES && levels_due.size() != 0; w++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (levels_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", levels_due.size()));
      if (mismatches == 0)
         $display("char_lcd_bus_sequencer_top_test: clean");
      else
         $display("char_lcd_bus_sequencer_top_test: errors");
      $finish;
   end

   // about 2k items with idling gaps; end the run with errors if it has not finished
   initial begin
      #(64'd40_000_000);
      $display("char_lcd_bus_sequencer_top_test: errors");
      $finish;
   end

endmodule
